[rtl/adv_data_name_extractor_macros.svh]
// Assertion macros shared by the checker.
`ifndef ADV_DATA_NAME_EXTRACTOR_MACROS_SVH
`define ADV_DATA_NAME_EXTRACTOR_MACROS_SVH

// Checked on every edge outside reset.
`define ADN_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("adn check failed");

// Checked on every edge, reset included.
`define ADN_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("adn check failed");

`endif

[rtl/adn_pkg.sv]
package adn_pkg;

  // Name positions never exceed 31 (name store holds at most 32 bytes)
  localparam int POS_W = 5;

  // Command queue depth between parser and store engine
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register indexes
  localparam logic [7:0] CFG_COMPLETE_TYPE = 8'd0;
  localparam logic [7:0] CFG_SHORT_TYPE    = 8'd1;

  // Register reset values
  localparam logic [7:0] COMPLETE_TYPE_RST = 8'd9;
  localparam logic [7:0] SHORT_TYPE_RST    = 8'd8;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } in_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       name_end;
  } out_t;

  // Work for the store engine, one per payload beat that needs any
  typedef struct packed {
    logic             clear;
    logic             wr;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic             commit;
    logic [POS_W-1:0] len;
    logic             emit;
  } cmd_t;

  // Parser phase
  typedef enum logic [3:0] {
    PH_LENGTH  = 4'b0001,
    PH_TYPE    = 4'b0010,
    PH_DATA    = 4'b0100,
    PH_STOPPED = 4'b1000
  } phase_t;

  // Store engine state
  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_COPY = 3'b010,
    B_EMIT = 3'b100
  } bstate_t;

endpackage

[rtl/adn_front.sv]
module adn_front #(
  parameter int NAME_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pl_valid,
  output logic              pl_ready,
  input  adn_pkg::in_t      pl_data,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              push,
  output adn_pkg::cmd_t     push_cmd,
  input  logic              q_full
);

  adn_pkg::phase_t             phase, phase_next, phase_eff;
  logic [7:0]                  left, left_next, left_eff, left_dec, dlen, pos_full;
  logic                        field_is_name, isname_next, isname_eff, match;
  logic [adn_pkg::POS_W-1:0]   plen, plen_next;
  logic                        at_start;
  logic [7:0]                  complete_type, short_type;
  logic                        accept;
  logic [7:0]                  b;

  assign pl_ready = !q_full;
  assign accept   = pl_valid && pl_ready;
  assign b        = pl_data.payload_byte;

  // Classify one payload beat and build its command
  always_comb begin
    phase_eff  = at_start ? adn_pkg::PH_LENGTH : phase;
    left_eff   = at_start ? 8'd0 : left;
    isname_eff = at_start ? 1'b0 : field_is_name;

    phase_next  = phase_eff;
    left_next   = left_eff;
    isname_next = isname_eff;
    plen_next   = plen;

    dlen     = left_eff - 8'd1;
    left_dec = left_eff - 8'd1;
    pos_full = {{(8 - adn_pkg::POS_W){1'b0}}, plen} - left_eff;
    match    = ((b == complete_type) || (b == short_type)) && (dlen < 8'(NAME_SIZE));

    push_cmd.clear  = at_start;
    push_cmd.wr     = 1'b0;
    push_cmd.pos    = pos_full[adn_pkg::POS_W-1:0];
    push_cmd.data   = b;
    push_cmd.commit = 1'b0;
    push_cmd.len    = plen;
    push_cmd.emit   = pl_data.payload_end;

    case (phase_eff)
      adn_pkg::PH_LENGTH: begin
        if (b == 8'd0) begin
          phase_next = adn_pkg::PH_STOPPED;
        end else begin
          left_next  = b;
          phase_next = adn_pkg::PH_TYPE;
        end
      end
      adn_pkg::PH_TYPE: begin
        left_next   = dlen;
        isname_next = match;
        plen_next   = match ? dlen[adn_pkg::POS_W-1:0] : '0;
        if (dlen == 8'd0) begin
          // type byte only: a matching type commits an empty name
          push_cmd.commit = match;
          push_cmd.len    = plen_next;
          phase_next      = adn_pkg::PH_LENGTH;
        end else begin
          phase_next = adn_pkg::PH_DATA;
        end
      end
      adn_pkg::PH_DATA: begin
        push_cmd.wr = isname_eff;
        left_next   = left_dec;
        if (left_dec == 8'd0) begin
          push_cmd.commit = isname_eff;
          phase_next      = adn_pkg::PH_LENGTH;
        end
      end
      adn_pkg::PH_STOPPED: begin
      end
      default: begin
        phase_next = adn_pkg::PH_LENGTH;
      end
    endcase
  end

  assign push = accept && (push_cmd.clear || push_cmd.wr || push_cmd.commit || push_cmd.emit);

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= adn_pkg::PH_LENGTH;
      left          <= 8'd0;
      field_is_name <= 1'b0;
      plen          <= '0;
      at_start      <= 1'b1;
    end else if (accept) begin
      phase         <= phase_next;
      left          <= left_next;
      field_is_name <= isname_next;
      plen          <= plen_next;
      at_start      <= pl_data.payload_end;
    end
  end

  // Type code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      complete_type <= adn_pkg::COMPLETE_TYPE_RST;
      short_type    <= adn_pkg::SHORT_TYPE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        adn_pkg::CFG_COMPLETE_TYPE: complete_type <= cfg_data;
        adn_pkg::CFG_SHORT_TYPE:    short_type    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/adn_fifo.sv]
module adn_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  adn_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output adn_pkg::cmd_t pop_cmd
);

  adn_pkg::cmd_t                mem [adn_pkg::Q_DEPTH];
  logic [adn_pkg::Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [adn_pkg::Q_CNT_W-1:0]  count;
  logic                         do_push, do_pop;

  assign full    = (count == adn_pkg::Q_CNT_W'(adn_pkg::Q_DEPTH));
  assign valid   = (count != '0);
  assign pop_cmd = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

endmodule

[rtl/adn_back.sv]
module adn_back #(
  parameter int NAME_SIZE = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  adn_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          nm_valid,
  input  logic          nm_ready,
  output adn_pkg::out_t nm_data
);

  localparam int IDX_W = $clog2(NAME_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NAME_SIZE - 1);

  adn_pkg::bstate_t       state;
  logic [7:0]             name_mem [NAME_SIZE];
  logic [NAME_SIZE-1:0]   name_vld;
  logic [7:0]             pend_mem [NAME_SIZE];
  logic [IDX_W-1:0]       cnt, len;
  logic                   emit_pend;
  logic                   emit_load;
  logic [7:0]             name_rd;

  assign q_pop     = (state == adn_pkg::B_IDLE) && q_valid;
  assign emit_load = (state == adn_pkg::B_EMIT) && (!nm_valid || nm_ready);
  // entries not written since the last clear read as zero
  assign name_rd   = name_vld[cnt] ? name_mem[cnt] : 8'd0;

  // Sequencer: take a command, copy a committed name, stream the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adn_pkg::B_IDLE;
      name_vld  <= '0;
      cnt       <= '0;
      len       <= '0;
      emit_pend <= 1'b0;
    end else begin
      case (state)
        adn_pkg::B_IDLE: begin
          if (q_valid) begin
            if (q_cmd.clear) name_vld <= '0;
            emit_pend <= q_cmd.emit;
            len       <= q_cmd.len[IDX_W-1:0];
            cnt       <= '0;
            if (q_cmd.commit) begin
              state <= adn_pkg::B_COPY;
            end else if (q_cmd.emit) begin
              state <= adn_pkg::B_EMIT;
            end
          end
        end
        adn_pkg::B_COPY: begin
          name_vld[cnt] <= 1'b1;
          if (cnt == len) begin
            cnt   <= '0;
            state <= emit_pend ? adn_pkg::B_EMIT : adn_pkg::B_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        adn_pkg::B_EMIT: begin
          if (emit_load) begin
            if (cnt == LAST_IDX) begin
              state <= adn_pkg::B_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= adn_pkg::B_IDLE;
        end
      endcase
    end
  end

  // Output valid: set on a load, dropped once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (emit_load) begin
      nm_valid <= 1'b1;
    end else if (nm_ready) begin
      nm_valid <= 1'b0;
    end
  end

  // Pending name bytes
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr) pend_mem[q_cmd.pos[IDX_W-1:0]] <= q_cmd.data;
  end

  // Name store copy, terminator after the last byte
  always_ff @(posedge clk) begin
    if (state == adn_pkg::B_COPY) begin
      name_mem[cnt] <= (cnt == len) ? 8'd0 : pend_mem[cnt];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      nm_data.name_byte <= name_rd;
      nm_data.name_end  <= (cnt == LAST_IDX);
    end
  end

endmodule

[rtl/adv_data_name_extractor.sv]
// Channel  | Dir | Handshake            | Beat
// ---------+-----+----------------------+-------------------------------------
// pl       | in  | pl_valid / pl_ready  | payload_byte, payload_end
// nm       | out | nm_valid / nm_ready  | name_byte, name_end
// cfg      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The parser takes one payload beat per cycle while its 4-entry command queue has room.
// The store engine takes one queued command at a time, copies a committed name with its
// terminator, and streams the whole store, NAME_SIZE bytes, one per accepted nm beat.
// Synchronous active-high reset; no clearing pass, the name store resets through valid bits.
// A stall on nm holds the store engine; the parser keeps going until the queue fills.
module adv_data_name_extractor #(
  parameter int NAME_SIZE = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pl_valid,
  output logic          pl_ready,
  input  adn_pkg::in_t  pl_data,
  output logic          nm_valid,
  input  logic          nm_ready,
  output adn_pkg::out_t nm_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [7:0]    cfg_data
);

  logic          push, q_full, q_valid, q_pop;
  adn_pkg::cmd_t push_cmd, q_cmd;

  assign cfg_ready = 1'b1;

  adn_front #(.NAME_SIZE(NAME_SIZE)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pl_valid  (pl_valid),
    .pl_ready  (pl_ready),
    .pl_data   (pl_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  adn_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  adn_back #(.NAME_SIZE(NAME_SIZE)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .nm_valid (nm_valid),
    .nm_ready (nm_ready),
    .nm_data  (nm_data)
  );

endmodule

[rtl/adn_checker.sv]
`include "adv_data_name_extractor_macros.svh"

module adn_checker (
  input logic          clk,
  input logic          rst,
  input logic          nm_valid,
  input logic          nm_ready,
  input adn_pkg::out_t nm_data
);

  // Stalled name beat stays offered and unchanged
  `ADN_ASSERT(a_nm_hold, nm_valid && !nm_ready |=> nm_valid)
  `ADN_ASSERT(a_nm_stable, nm_valid && !nm_ready |=> $stable(nm_data))
  // A name run streams without gaps until its last byte
  `ADN_ASSERT(a_run_gapless, nm_valid && nm_ready && !nm_data.name_end |=> nm_valid)
  // Nothing offered right after reset
  `ADN_ASSERT_ALWAYS(a_rst_quiet, rst |=> !nm_valid)

endmodule

bind adv_data_name_extractor adn_checker u_chk (.*);

[verif/tb.sv]
module tb;

  localparam int NAME_SIZE    = 16;
  localparam int RANDOM_BEATS = 470;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  // One directed payload beat; name0 is typed in only where the whole
  // name store is zero past position 0
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [7:0] name0;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [23] = '{
    // zero length straight away: empty store
    '{8'h00, 1'b1, 1'b1, 8'h00},
    // type byte only: empty name committed
    '{8'h01, 1'b0, 1'b0, 8'h00},
    '{8'h09, 1'b1, 1'b1, 8'h00},
    // complete name "AB"
    '{8'h03, 1'b0, 1'b0, 8'h00},
    '{8'h09, 1'b0, 1'b0, 8'h00},
    '{8'h41, 1'b0, 1'b0, 8'h00},
    '{8'h42, 1'b1, 1'b0, 8'h00},
    // max length, foreign type, cut short by the payload end
    '{8'hff, 1'b0, 1'b0, 8'h00},
    '{8'hff, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, 8'h00},
    // short name "xyz" then complete name "q": tail of the longer one stays
    '{8'h04, 1'b0, 1'b0, 8'h00},
    '{8'h08, 1'b0, 1'b0, 8'h00},
    '{8'h78, 1'b0, 1'b0, 8'h00},
    '{8'h79, 1'b0, 1'b0, 8'h00},
    '{8'h7a, 1'b0, 1'b0, 8'h00},
    '{8'h02, 1'b0, 1'b0, 8'h00},
    '{8'h09, 1'b0, 1'b0, 8'h00},
    '{8'h71, 1'b1, 1'b0, 8'h00},
    // name, then a zero length stops parsing
    '{8'h02, 1'b0, 1'b0, 8'h00},
    '{8'h08, 1'b0, 1'b0, 8'h00},
    '{8'h7f, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h05, 1'b1, 1'b0, 8'h00}
  };

  logic          clk;
  logic          rst       = 1'b1;
  logic          pl_valid  = 1'b0;
  logic          pl_ready;
  adn_pkg::in_t  pl_data   = '0;
  logic          nm_valid;
  logic          nm_ready  = 1'b0;
  adn_pkg::out_t nm_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [7:0]    cfg_index = '0;
  logic [7:0]    cfg_data  = '0;

  // Mirror of the extractor
  logic [7:0]        full_type  = adn_pkg::COMPLETE_TYPE_RST;
  logic [7:0]        short_type = adn_pkg::SHORT_TYPE_RST;
  logic [7:0]        name_mem [NAME_SIZE];
  logic [7:0]        pend_mem [NAME_SIZE];
  adn_pkg::phase_t   parse_at   = adn_pkg::PH_LENGTH;
  logic [7:0]        left       = '0;
  logic              is_name    = 1'b0;
  logic [4:0]        pend_len   = '0;
  logic              fresh      = 1'b1;

  adn_pkg::out_t want_names [$];
  adn_pkg::out_t want;
  logic [7:0]    frame_q [$];
  logic          calm       = 1'b0;
  int            mismatches = 0;
  int unsigned   cycles     = 0;

  adv_data_name_extractor #(.NAME_SIZE(NAME_SIZE)) dut (
    .clk       (clk),
    .rst       (rst),
    .pl_valid  (pl_valid),
    .pl_ready  (pl_ready),
    .pl_data   (pl_data),
    .nm_valid  (nm_valid),
    .nm_ready  (nm_ready),
    .nm_data   (nm_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Copy the pending name into the store, then its terminator
  task automatic commit_name();
    for (int i = 0; i < int'(pend_len); i++) name_mem[i] = pend_mem[i];
    name_mem[pend_len] = 8'h00;
  endtask

  // Advance the mirror by one accepted payload beat; queue the name run on the last
  task automatic track_payload_byte(input logic [7:0] b, input logic last,
                                    input logic typed, input logic [7:0] name0);
    int            pos;
    adn_pkg::out_t r;
    if (fresh) begin
      foreach (name_mem[i]) name_mem[i] = 8'h00;
      parse_at = adn_pkg::PH_LENGTH;
      left     = '0;
      is_name  = 1'b0;
      fresh    = 1'b0;
    end
    case (parse_at)
      adn_pkg::PH_LENGTH: begin
        if (b == 8'h00) parse_at = adn_pkg::PH_STOPPED;
        else begin
          left     = b;
          parse_at = adn_pkg::PH_TYPE;
        end
      end
      adn_pkg::PH_TYPE: begin
        left     = left - 8'd1;
        is_name  = (b == full_type || b == short_type) && int'(left) < NAME_SIZE;
        pend_len = is_name ? left[4:0] : 5'd0;
        if (left == 8'd0) begin
          if (is_name) commit_name();
          parse_at = adn_pkg::PH_LENGTH;
        end else parse_at = adn_pkg::PH_DATA;
      end
      adn_pkg::PH_DATA: begin
        if (is_name && int'(left) <= int'(pend_len)) begin
          pos = int'(pend_len) - int'(left);
          if (pos < NAME_SIZE) pend_mem[pos] = b;
        end
        left = left - 8'd1;
        if (left == 8'd0) begin
          if (is_name) commit_name();
          parse_at = adn_pkg::PH_LENGTH;
        end
      end
      default: ;
    endcase
    if (last) begin
      for (int i = 0; i < NAME_SIZE; i++) begin
        if (typed) r.name_byte = (i == 0) ? name0 : 8'h00;
        else r.name_byte = name_mem[i];
        r.name_end = (i == NAME_SIZE - 1);
        want_names.push_back(r);
      end
      fresh = 1'b1;
    end
  endtask

  // Present one payload beat, hold it until taken
  task automatic send_beat(input logic [7:0] b, input logic last,
                           input logic typed, input logic [7:0] name0);
    while (!calm && $urandom_range(99) < 37) begin
      pl_valid <= 1'b0;
      @(posedge clk);
    end
    pl_valid <= 1'b1;
    pl_data  <= '{payload_byte: b, payload_end: last};
    @(posedge clk);
    while (!pl_ready) @(posedge clk);
    track_payload_byte(b, last, typed, name0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    while ($urandom_range(99) < 37) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == adn_pkg::CFG_COMPLETE_TYPE) full_type = val;
    else if (idx == adn_pkg::CFG_SHORT_TYPE) short_type = val;
  endtask

  // Drain, then load a new pair of type codes plus one write to a dead index
  task automatic reconfigure(input int k);
    logic [7:0] new_full;
    logic [7:0] new_short;
    case (k % 5)
      0: begin new_full = 8'h00; new_short = 8'hff; end
      1: begin new_full = 8'hff; new_short = 8'h00; end
      2: begin new_full = 8'h55; new_short = 8'h55; end
      3: begin new_full = 8'($urandom); new_short = 8'($urandom); end
      default: begin
        new_full  = adn_pkg::COMPLETE_TYPE_RST;
        new_short = adn_pkg::SHORT_TYPE_RST;
      end
    endcase
    pl_valid <= 1'b0;
    while (want_names.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(adn_pkg::CFG_COMPLETE_TYPE, new_full);
    write_reg(adn_pkg::CFG_SHORT_TYPE, new_short);
    write_reg(8'($urandom_range(2, 255)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed payloads of 1..4 structures; some noise, cut or stopped
  task automatic build_frame();
    int         sel;
    int         sel_kind;
    int         dlen;
    int         cut;
    logic [7:0] kind;
    frame_q.delete();
    sel = $urandom_range(99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      sel_kind = $urandom_range(99);
      if (sel_kind < 35) kind = full_type;
      else if (sel_kind < 65) kind = short_type;
      else kind = 8'($urandom);
      dlen = ($urandom_range(99) < 85) ? $urandom_range(0, 15) : $urandom_range(16, 20);
      frame_q.push_back(8'(dlen + 1));
      frame_q.push_back(kind);
      repeat (dlen) frame_q.push_back(8'($urandom));
    end
    if (sel < 24) begin
      cut = $urandom_range(0, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
      // cut payloads may end mid-structure; the others hit a zero length first
      if (sel >= 16 || cut == 0) begin
        frame_q.push_back(8'h00);
        repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
      end
    end
  endtask

  // Stall the name side
  always @(posedge clk) nm_ready <= calm || ($urandom_range(99) >= 37);

  // Compare each name beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && nm_valid && nm_ready) begin
      if (want_names.size() == 0) begin
        $display("%0t: unexpected name beat, expected none, got byte %h end %b",
                 $time, nm_data.name_byte, nm_data.name_end);
        mismatches++;
      end else begin
        want = want_names.pop_front();
        if (nm_data.name_byte !== want.name_byte) begin
          $display("%0t: name_byte expected %h got %h",
                   $time, want.name_byte, nm_data.name_byte);
          mismatches++;
        end
        if (nm_data.name_end !== want.name_end) begin
          $display("%0t: name_end expected %b got %b",
                   $time, want.name_end, nm_data.name_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d name beats outstanding",
               cycles, want_names.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int fed;
    int frame_no;
    foreach (name_mem[i]) name_mem[i] = 8'h00;
    foreach (pend_mem[i]) pend_mem[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed payloads at reset type codes
    foreach (DIR_ROWS[i])
      send_beat(DIR_ROWS[i].b, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].name0);

    // Random payloads, new type codes every few payloads
    fed      = 0;
    frame_no = 0;
    while (fed < RANDOM_BEATS) begin
      if (frame_no % 5 == 0) reconfigure(frame_no / 5);
      calm = (frame_no >= 12 && frame_no < 20);
      build_frame();
      foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1, 1'b0, 8'h00);
      fed += frame_q.size();
      frame_no++;
    end
    calm = 1'b0;
    pl_valid <= 1'b0;

    while (want_names.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
